>>> hw/rtl/refraction_normal_from_target_macros.svh
// Assertion macros shared by the refraction normal checker.
`ifndef REFRACTION_NORMAL_FROM_TARGET_MACROS_SVH
`define REFRACTION_NORMAL_FROM_TARGET_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define RNFT_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rnft check failed");

// Next-cycle implication, disabled while reset is low.
`define RNFT_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rnft check failed");

`endif

>>> hw/rtl/rnft_pkg.sv
// Types and constants for the refraction normal pipeline.
package rnft_pkg;

	localparam int REFR_W         = 18;
	localparam logic [REFR_W-1:0] REFR_RESET = 18'd97649;
	localparam int Q_W            = 32;
	localparam int SC_W           = 30;
	localparam int ROOT_W         = 32;
	localparam int STEPS          = 4;
	localparam int ROOT_STAGES    = ROOT_W / STEPS;
	localparam int DIV_STAGES     = Q_W / STEPS;
	localparam logic [Q_W-1:0] ONE_Q30 = 32'h4000_0000;

	typedef struct packed {
		logic signed [31:0] vertex_x;
		logic signed [31:0] vertex_y;
		logic signed [31:0] vertex_z;
		logic signed [31:0] target_x;
		logic signed [31:0] target_y;
		logic signed [31:0] target_z;
	} vtx_t;

	typedef struct packed {
		logic signed [31:0] normal_x;
		logic signed [31:0] normal_y;
		logic signed [31:0] normal_z;
		logic               degenerate;
	} nrm_t;

	typedef struct packed {
		logic                      zero;
		logic [2:0]                neg;
		logic [2:0][SC_W-1:0]      sc;
	} side_t;

endpackage

>>> hw/rtl/rnft_unit3.sv
// Pipelined 3-vector normaliser: scale, squares, square root, three dividers.
module rnft_unit3 import rnft_pkg::*; #(
	parameter int MAG_W = 34
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic                    in_valid,
	input  logic [2:0][MAG_W-1:0]   vec,
	output logic                    out_valid,
	output logic [2:0][Q_W-1:0]     uvec,
	output logic                    zero
);

	localparam int PW = $clog2(MAG_W);

	logic [2:0][MAG_W-1:0] mag_c;
	logic [MAG_W-1:0]      max01_c, max_c;
	logic [PW-1:0]         pos_c;
	side_t                 side_c;
	logic [2:0][59:0]      sq_c;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;
	logic [2:0]            neg_s1, neg_s2, neg_s3;
	logic [2:0][MAG_W-1:0] mag_s1, mag_s2, mag_s3;
	logic [MAG_W-1:0]      max_s2;
	logic [PW-1:0]         pos_s3;
	logic                  zero_s3;
	side_t                 side_s4, side_s5, side_s6, side_s7;
	logic [2:0][59:0]      sq_s5;
	logic [61:0]           sum_s6;

	logic                  rt_v_s    [ROOT_STAGES];
	logic [35:0]           rt_rem_s  [ROOT_STAGES];
	logic [ROOT_W-1:0]     rt_root_s [ROOT_STAGES];
	logic [63:0]           rt_rad_s  [ROOT_STAGES];
	side_t                 rt_side_s [ROOT_STAGES];

	logic [2:0][32:0]      nm_rem_c, nm_rem_s7;
	logic [2:0][31:0]      nm_rest_c, nm_rest_s7;
	logic [ROOT_W-1:0]     len_s7;

	logic                  dv_v_s    [DIV_STAGES];
	logic [2:0][32:0]      dv_rem_s  [DIV_STAGES];
	logic [2:0][Q_W-1:0]   dv_q_s    [DIV_STAGES];
	logic [2:0][31:0]      dv_rest_s [DIV_STAGES];
	logic [ROOT_W-1:0]     dv_len_s  [DIV_STAGES];
	side_t                 dv_side_s [DIV_STAGES];

	logic [2:0][Q_W-1:0]   res_c, res_s8;
	logic                  zero_s8;

	// front end: magnitudes, maximum, leading one, common scale
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mag_c[i] = vec[i][MAG_W-1] ? MAG_W'(~vec[i] + MAG_W'(1)) : vec[i];
		end
		max01_c = (mag_s1[0] > mag_s1[1]) ? mag_s1[0] : mag_s1[1];
		max_c   = (max01_c > mag_s1[2]) ? max01_c : mag_s1[2];
		pos_c   = '0;
		for (int i = 0; i < MAG_W; i++) begin
			if (max_s2[i]) pos_c = PW'(i);
		end
		side_c.zero = zero_s3;
		side_c.neg  = neg_s3;
		for (int i = 0; i < 3; i++) begin
			if (pos_s3 >= PW'(SC_W - 1))
				side_c.sc[i] = SC_W'(mag_s3[i] >> (pos_s3 - PW'(SC_W - 1)));
			else
				side_c.sc[i] = SC_W'(mag_s3[i] << (PW'(SC_W - 1) - pos_s3));
		end
		for (int i = 0; i < 3; i++) begin
			sq_c[i] = 60'(side_s4.sc[i]) * 60'(side_s4.sc[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0;
			v_s5 <= 1'b0; v_s6 <= 1'b0; v_s7 <= 1'b0; v_s8 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= rt_v_s[ROOT_STAGES-1];
			v_s8 <= dv_v_s[DIV_STAGES-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) neg_s1[i] <= vec[i][MAG_W-1];
			mag_s1  <= mag_c;
			neg_s2  <= neg_s1;
			mag_s2  <= mag_s1;
			max_s2  <= max_c;
			neg_s3  <= neg_s2;
			mag_s3  <= mag_s2;
			pos_s3  <= pos_c;
			zero_s3 <= (max_s2 == '0);
			side_s4 <= side_c;
			side_s5 <= side_s4;
			sq_s5   <= sq_c;
			side_s6 <= side_s5;
			sum_s6  <= 62'(sq_s5[0]) + 62'(sq_s5[1]) + 62'(sq_s5[2]);
		end
	end

	// square root, STEPS result bits per stage
	for (genvar k = 0; k < ROOT_STAGES; k++) begin : g_rt
		logic              vi;
		logic [35:0]       ri, rn, tr;
		logic [ROOT_W-1:0] oi, on;
		logic [63:0]       di, dn;
		side_t             si;

		if (k == 0) begin : g_first
			assign vi = v_s6;
			assign ri = '0;
			assign oi = '0;
			assign di = {2'b00, sum_s6};
			assign si = side_s6;
		end else begin : g_next
			assign vi = rt_v_s[k-1];
			assign ri = rt_rem_s[k-1];
			assign oi = rt_root_s[k-1];
			assign di = rt_rad_s[k-1];
			assign si = rt_side_s[k-1];
		end

		always_comb begin
			rn = ri;
			on = oi;
			dn = di;
			tr = '0;
			for (int j = 0; j < STEPS; j++) begin
				rn = {rn[33:0], dn[63:62]};
				dn = {dn[61:0], 2'b00};
				tr = {2'b00, on, 2'b01};
				if (rn >= tr) begin
					rn = rn - tr;
					on = {on[ROOT_W-2:0], 1'b1};
				end else begin
					on = {on[ROOT_W-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) rt_v_s[k] <= 1'b0;
			else if (en) rt_v_s[k] <= vi;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rt_rem_s[k]  <= rn;
				rt_root_s[k] <= on;
				rt_rad_s[k]  <= dn;
				rt_side_s[k] <= si;
			end
		end
	end

	// rounded dividend: (sc << 30) + len/2
	always_comb begin
		logic [63:0] num;
		for (int i = 0; i < 3; i++) begin
			num = {4'b0, rt_side_s[ROOT_STAGES-1].sc[i], 30'b0}
				+ {33'b0, rt_root_s[ROOT_STAGES-1][ROOT_W-1:1]};
			nm_rem_c[i]  = {1'b0, num[63:32]};
			nm_rest_c[i] = num[31:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nm_rem_s7  <= nm_rem_c;
			nm_rest_s7 <= nm_rest_c;
			len_s7     <= rt_root_s[ROOT_STAGES-1];
			side_s7    <= rt_side_s[ROOT_STAGES-1];
		end
	end

	// three restoring dividers side by side
	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_dv
		logic              vi;
		logic [2:0][32:0]  ri, rn;
		logic [2:0][Q_W-1:0] qi, qn;
		logic [2:0][31:0]  si_rest, sn_rest;
		logic [ROOT_W-1:0] li;
		side_t             si;

		if (k == 0) begin : g_first
			assign vi      = v_s7;
			assign ri      = nm_rem_s7;
			assign qi      = '0;
			assign si_rest = nm_rest_s7;
			assign li      = len_s7;
			assign si      = side_s7;
		end else begin : g_next
			assign vi      = dv_v_s[k-1];
			assign ri      = dv_rem_s[k-1];
			assign qi      = dv_q_s[k-1];
			assign si_rest = dv_rest_s[k-1];
			assign li      = dv_len_s[k-1];
			assign si      = dv_side_s[k-1];
		end

		always_comb begin
			rn      = ri;
			qn      = qi;
			sn_rest = si_rest;
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < STEPS; j++) begin
					rn[i]      = {rn[i][31:0], sn_rest[i][31]};
					sn_rest[i] = {sn_rest[i][30:0], 1'b0};
					if (rn[i] >= {1'b0, li}) begin
						rn[i] = rn[i] - {1'b0, li};
						qn[i] = {qn[i][Q_W-2:0], 1'b1};
					end else begin
						qn[i] = {qn[i][Q_W-2:0], 1'b0};
					end
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) dv_v_s[k] <= 1'b0;
			else if (en) dv_v_s[k] <= vi;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dv_rem_s[k]  <= rn;
				dv_q_s[k]    <= qn;
				dv_rest_s[k] <= sn_rest;
				dv_len_s[k]  <= li;
				dv_side_s[k] <= si;
			end
		end
	end

	// clamp to one, restore sign, zero vector gives zeros
	always_comb begin
		logic [Q_W-1:0] q;
		for (int i = 0; i < 3; i++) begin
			q = dv_q_s[DIV_STAGES-1][i];
			if (q > ONE_Q30) q = ONE_Q30;
			if (dv_side_s[DIV_STAGES-1].zero)
				res_c[i] = '0;
			else if (dv_side_s[DIV_STAGES-1].neg[i])
				res_c[i] = Q_W'(~q + Q_W'(1));
			else
				res_c[i] = q;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s8  <= res_c;
			zero_s8 <= dv_side_s[DIV_STAGES-1].zero;
		end
	end

	assign out_valid = v_s8;
	assign uvec      = res_s8;
	assign zero      = zero_s8;

endmodule

>>> hw/rtl/refraction_normal_from_target.sv
// Top level: refraction normal from vertex and target point.
//
// One transaction per clock is taken while vtx_stall is low, and results come
// out in order. Most of the pipeline lies in the two normalisers (24 stages
// each): every one holds a square root and three dividers that resolve four
// bits per stage. An output register plus a one-entry skid buffer sit at the
// end, so a new transaction is still accepted while a finished result waits;
// vtx_stall rises only once the skid entry is full, and then the whole
// pipeline holds.
module refraction_normal_from_target import rnft_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              vtx_valid,
	output logic              vtx_stall,
	input  vtx_t              vtx,
	output logic              nrm_valid,
	input  logic              nrm_stall,
	output nrm_t              nrm,
	input  logic              cfg_we,
	input  logic [REFR_W-1:0] cfg_data
);

	localparam int N30_SH = 30 - FRAC_BITS;
	localparam int N30_W  = REFR_W + N30_SH;
	localparam int MAG_W  = ((N30_W > 32) ? N30_W : 32) + 2;

	logic                  en;
	logic [REFR_W-1:0]     refr_q;
	logic                  v_s1, v_s2;
	logic [2:0][MAG_W-1:0] d_s1, w_s2, w_c;
	logic                  u1_v, u1_zero, u2_v, u2_zero;
	logic [2:0][Q_W-1:0]   u1_t, u2_n;
	nrm_t                  pipe_item;
	logic                  out_v_q, skid_v_q;
	nrm_t                  out_q, skid_q;
	logic                  take, pipe_out;

	assign en        = ~skid_v_q;
	assign vtx_stall = skid_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) refr_q <= REFR_RESET;
		else if (cfg_we) refr_q <= cfg_data;
	end

	// direction target - vertex, exact
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= vtx_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s1[0] <= MAG_W'(vtx.target_x) - MAG_W'(vtx.vertex_x);
			d_s1[1] <= MAG_W'(vtx.target_y) - MAG_W'(vtx.vertex_y);
			d_s1[2] <= MAG_W'(vtx.target_z) - MAG_W'(vtx.vertex_z);
		end
	end

	rnft_unit3 #(.MAG_W(MAG_W)) u_dir (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s1),
		.vec      (d_s1),
		.out_valid(u1_v),
		.uvec     (u1_t),
		.zero     (u1_zero)
	);

	// w = -(t.x, t.y, t.z + n); a zero direction forces w to zero
	always_comb begin
		logic [MAG_W-1:0] n30;
		n30 = MAG_W'(refr_q) << N30_SH;
		if (u1_zero) begin
			w_c = '0;
		end else begin
			w_c[0] = MAG_W'(-$signed(MAG_W'($signed(u1_t[0]))));
			w_c[1] = MAG_W'(-$signed(MAG_W'($signed(u1_t[1]))));
			w_c[2] = MAG_W'(-$signed(MAG_W'($signed(u1_t[2])) + $signed(n30)));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (en) v_s2 <= u1_v;
	end

	always_ff @(posedge clk) begin
		if (en) w_s2 <= w_c;
	end

	rnft_unit3 #(.MAG_W(MAG_W)) u_nrm (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s2),
		.vec      (w_s2),
		.out_valid(u2_v),
		.uvec     (u2_n),
		.zero     (u2_zero)
	);

	assign pipe_item.normal_x   = u2_n[0];
	assign pipe_item.normal_y   = u2_n[1];
	assign pipe_item.normal_z   = u2_n[2];
	assign pipe_item.degenerate = u2_zero;

	assign take     = out_v_q & ~nrm_stall;
	assign pipe_out = u2_v & en;

	// output register with one skid entry behind it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!out_v_q || take) begin
			if (skid_v_q) begin
				out_v_q  <= 1'b1;
				out_q    <= skid_q;
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= pipe_out;
				out_q   <= pipe_item;
			end
		end else if (pipe_out) begin
			skid_v_q <= 1'b1;
			skid_q   <= pipe_item;
		end
	end

	assign nrm_valid = out_v_q;
	assign nrm       = out_q;

endmodule

>>> hw/rtl/rnft_checker.sv
// Port-level checks on the refraction normal block, bound to the top level.
`include "refraction_normal_from_target_macros.svh"

module rnft_checker import rnft_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              vtx_valid,
	input logic              vtx_stall,
	input vtx_t              vtx,
	input logic              nrm_valid,
	input logic              nrm_stall,
	input nrm_t              nrm
);

	// a stalled input transaction holds
	`RNFT_ASSERT_NXT(a_in_hold, vtx_valid && vtx_stall, vtx_valid && $stable(vtx))

	// a stalled result transaction holds
	`RNFT_ASSERT_NXT(a_out_hold, nrm_valid && nrm_stall, nrm_valid && $stable(nrm))

	// degenerate results carry a zero normal
	`RNFT_ASSERT_IMP(a_deg_zero, nrm_valid && nrm.degenerate, {nrm.normal_x, nrm.normal_y, nrm.normal_z} == '0)

	// a proper normal is never the zero vector
	`RNFT_ASSERT_IMP(a_nondeg_nz, nrm_valid && !nrm.degenerate, {nrm.normal_x, nrm.normal_y, nrm.normal_z} != '0)

	// input back-pressure only builds up behind a stalled output
	`RNFT_ASSERT_IMP(a_stall_cause, $rose(vtx_stall), $past(nrm_valid && nrm_stall))

endmodule

bind refraction_normal_from_target rnft_checker u_rnft_checker (.*);
